@@ sv/border_gateway_header_rewrite_unit_macros.svh @@
// assertion macros for the header rewrite unit
`ifndef BORDER_GATEWAY_HEADER_REWRITE_UNIT_MACROS_SVH
`define BORDER_GATEWAY_HEADER_REWRITE_UNIT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define BGHR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define BGHR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/bghr_pkg.sv @@
package bghr_pkg;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_DOWNSTREAM_PREFIX = 2'd0;
	localparam logic [1:0] REG_PREFIX_LENGTH     = 2'd1;
	localparam logic [1:0] REG_UPSTREAM_ADDRESS  = 2'd2;
	localparam logic [1:0] REG_PROTOCOL_NUMBER   = 2'd3;

	localparam logic [5:0] PREFIX_LENGTH_RESET   = 6'd24;
	localparam logic [7:0] PROTOCOL_NUMBER_RESET = 8'd155;

	localparam logic [3:0] VERSION_MAJOR = 4'd4;
	localparam logic [3:0] VERSION_MINOR = 4'd5;
	localparam logic [5:0] ADDR_BITS     = 6'd32;
	localparam logic [8:0] SRC_EXT_LIMIT = 9'd12;
	localparam logic [7:0] DST_EXT_LIMIT = 8'd16;

	typedef struct packed {
		logic [31:0] downstream_prefix;
		logic [5:0]  prefix_length;
		logic [31:0] upstream_address;
		logic [7:0]  protocol_number;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  major_version;
		logic [3:0]  minor_version;
		logic [7:0]  proto;
		logic [31:0] src_address;
		logic [31:0] dst_address;
		logic [63:0] src_ext_high;
		logic [63:0] src_ext_low;
		logic [63:0] dst_ext_high;
		logic [63:0] dst_ext_low;
		logic [7:0]  src_mark;
		logic [7:0]  dst_mark;
		logic [15:0] header_checksum;
	} hdr_t;

	typedef struct packed {
		logic        drop;
		logic        mark_overrun;
		logic [31:0] new_src_address;
		logic [31:0] new_dst_address;
		logic [63:0] new_src_ext_high;
		logic [63:0] new_src_ext_low;
		logic [7:0]  new_src_mark;
		logic [7:0]  new_dst_mark;
		logic [15:0] new_checksum;
	} res_t;

	// one's-complement incremental update for one changed 32-bit word
	function automatic logic [15:0] csum_update(input logic [15:0] hc,
			input logic [31:0] oldw, input logic [31:0] neww);
		logic [15:0] nhc;
		logic [15:0] nhi;
		logic [15:0] nlo;
		logic [18:0] s;
		logic [16:0] f1;
		logic [16:0] f2;
		nhc = ~hc;
		nhi = ~oldw[31:16];
		nlo = ~oldw[15:0];
		s  = 19'(nhc) + 19'(nhi) + 19'(nlo)
			+ 19'(neww[31:16]) + 19'(neww[15:0]);
		f1 = 17'(s[15:0]) + 17'(s[18:16]);
		f2 = 17'(f1[15:0]) + 17'(f1[16]);
		return ~f2[15:0];
	endfunction

endpackage

@@ sv/bghr_cfg_regs.sv @@
module bghr_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output bghr_pkg::cfg_t    cfg
);

	logic [31:0] downstream_prefix_q;
	logic [5:0]  prefix_length_q;
	logic [31:0] upstream_address_q;
	logic [7:0]  protocol_number_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			downstream_prefix_q <= '0;
			prefix_length_q     <= bghr_pkg::PREFIX_LENGTH_RESET;
			upstream_address_q  <= '0;
			protocol_number_q   <= bghr_pkg::PROTOCOL_NUMBER_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				bghr_pkg::REG_DOWNSTREAM_PREFIX: downstream_prefix_q <= pwdata;
				bghr_pkg::REG_PREFIX_LENGTH:     prefix_length_q     <= pwdata[5:0];
				bghr_pkg::REG_UPSTREAM_ADDRESS:  upstream_address_q  <= pwdata;
				bghr_pkg::REG_PROTOCOL_NUMBER:   protocol_number_q   <= pwdata[7:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			bghr_pkg::REG_DOWNSTREAM_PREFIX: prdata = downstream_prefix_q;
			bghr_pkg::REG_PREFIX_LENGTH:     prdata = {26'd0, prefix_length_q};
			bghr_pkg::REG_UPSTREAM_ADDRESS:  prdata = upstream_address_q;
			bghr_pkg::REG_PROTOCOL_NUMBER:   prdata = {24'd0, protocol_number_q};
		endcase
	end

	assign cfg.downstream_prefix = downstream_prefix_q;
	assign cfg.prefix_length     = prefix_length_q;
	assign cfg.upstream_address  = upstream_address_q;
	assign cfg.protocol_number   = protocol_number_q;

endmodule

@@ sv/bghr_rewrite.sv @@
module bghr_rewrite (
	input  bghr_pkg::hdr_t hdr,
	input  bghr_pkg::cfg_t cfg,
	output bghr_pkg::res_t res
);

	logic         hdr_ok;
	logic [5:0]   len;
	logic [2:0]   shlen;
	logic [5:0]   shbits;
	logic [31:0]  pmask;
	logic         src_match;
	logic [8:0]   nm;
	logic         src_over;
	logic         src_do;
	logic [3:0]   src_off;
	logic [127:0] sx;
	logic [127:0] sx_ins;
	logic [127:0] sx_msk;
	logic [127:0] sx_new;
	logic         dst_hit;
	logic         dst_over;
	logic         dst_do;
	logic [3:0]   dst_start;
	logic [127:0] dx_win;
	logic [31:0]  dst_tail;
	logic [31:0]  nd;
	logic [15:0]  csum1;
	logic [15:0]  csum2;

	assign hdr_ok = (hdr.major_version == bghr_pkg::VERSION_MAJOR)
		&& (hdr.minor_version == bghr_pkg::VERSION_MINOR)
		&& (hdr.proto == cfg.protocol_number);

	// prefix length clamped to 32, shift length in bytes
	assign len    = (cfg.prefix_length > bghr_pkg::ADDR_BITS) ? bghr_pkg::ADDR_BITS
		: cfg.prefix_length;
	assign shlen  = 3'((bghr_pkg::ADDR_BITS - len) >> 3);
	assign shbits = {shlen, 3'b000};
	assign pmask  = ~(32'hFFFF_FFFF >> len);

	// source side
	assign src_match = ((hdr.src_address ^ cfg.downstream_prefix) & pmask) == 32'd0;
	assign nm        = {1'b0, hdr.src_mark} + 9'(shlen);
	assign src_over  = src_match && (nm > bghr_pkg::SRC_EXT_LIMIT);
	assign src_do    = src_match && !src_over;
	assign src_off   = 4'(bghr_pkg::SRC_EXT_LIMIT - nm);
	assign sx        = {hdr.src_ext_high, hdr.src_ext_low};
	assign sx_ins    = {cfg.upstream_address, 96'd0} >> {src_off, 3'b000};
	assign sx_msk    = {32'hFFFF_FFFF, 96'd0} >> {src_off, 3'b000};
	assign sx_new    = (sx & ~sx_msk) | sx_ins;

	// destination side, tested on the original destination
	assign dst_hit   = (hdr.dst_address == cfg.upstream_address) && (hdr.dst_mark != 8'd0);
	assign dst_over  = dst_hit && ((hdr.dst_mark > bghr_pkg::DST_EXT_LIMIT)
		|| (hdr.dst_mark < 8'(shlen)));
	assign dst_do    = dst_hit && !dst_over;
	assign dst_start = 4'(bghr_pkg::DST_EXT_LIMIT - hdr.dst_mark);
	assign dx_win    = {hdr.dst_ext_high, hdr.dst_ext_low} << {dst_start, 3'b000};
	assign dst_tail  = dx_win[127:96] >> (bghr_pkg::ADDR_BITS - shbits);
	assign nd        = (cfg.downstream_prefix & (32'hFFFF_FFFF << shbits)) | dst_tail;

	assign csum1 = src_do ? bghr_pkg::csum_update(hdr.header_checksum, hdr.src_address,
		cfg.upstream_address) : hdr.header_checksum;
	assign csum2 = dst_do ? bghr_pkg::csum_update(csum1, hdr.dst_address, nd) : csum1;

	always_comb begin
		res.drop             = !hdr_ok;
		res.mark_overrun     = hdr_ok && (src_over || dst_over);
		res.new_src_address  = hdr.src_address;
		res.new_dst_address  = hdr.dst_address;
		res.new_src_ext_high = hdr.src_ext_high;
		res.new_src_ext_low  = hdr.src_ext_low;
		res.new_src_mark     = hdr.src_mark;
		res.new_dst_mark     = hdr.dst_mark;
		res.new_checksum     = hdr.header_checksum;
		if (hdr_ok) begin
			res.new_checksum = csum2;
			if (src_do) begin
				res.new_src_address  = cfg.upstream_address;
				res.new_src_ext_high = sx_new[127:64];
				res.new_src_ext_low  = sx_new[63:0];
				res.new_src_mark     = nm[7:0];
			end
			if (dst_do) begin
				res.new_dst_address = nd;
				res.new_dst_mark    = hdr.dst_mark - 8'(shlen);
			end
		end
	end

endmodule

@@ sv/border_gateway_header_rewrite_unit.sv @@
// the input item is registered in stage 1 and its rewrite result in stage 2, which drives m_tvalid
// throughput: one item per cycle, sustained while the output side keeps m_tready high
// the input side keeps taking items while a finished result waits, until both stages fill
// reset: arst_n async active low, clears both stage valids; config returns to
// prefix 0, length 24, upstream 0, protocol 155
module border_gateway_header_rewrite_unit (
	input  logic         clk,
	input  logic         arst_n,
	// input items
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, from bit 0: major_version(4) minor_version(4) proto(8) src_address(32)
	// dst_address(32) src_ext_high(64) src_ext_low(64) dst_ext_high(64) dst_ext_low(64)
	// src_mark(8) dst_mark(8) header_checksum(16)
	input  logic [367:0] s_tdata,
	// result items
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, from bit 0: new_src_address(32) new_dst_address(32) new_src_ext_high(64)
	// new_src_ext_low(64) new_src_mark(8) new_dst_mark(8) new_checksum(16)
	output logic [223:0] m_tdata,
	// m_tuser, from bit 0: drop(1) mark_overrun(1)
	output logic [1:0]   m_tuser,
	// configuration port
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	bghr_pkg::cfg_t cfg;
	bghr_pkg::hdr_t hdr_in;
	bghr_pkg::hdr_t hdr_s1;
	bghr_pkg::res_t res_next;
	bghr_pkg::res_t res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           load_s1;
	logic           load_s2;

	// configuration registers
	bghr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// unpack the input item
	assign hdr_in.major_version   = s_tdata[3:0];
	assign hdr_in.minor_version   = s_tdata[7:4];
	assign hdr_in.proto           = s_tdata[15:8];
	assign hdr_in.src_address     = s_tdata[47:16];
	assign hdr_in.dst_address     = s_tdata[79:48];
	assign hdr_in.src_ext_high    = s_tdata[143:80];
	assign hdr_in.src_ext_low     = s_tdata[207:144];
	assign hdr_in.dst_ext_high    = s_tdata[271:208];
	assign hdr_in.dst_ext_low     = s_tdata[335:272];
	assign hdr_in.src_mark        = s_tdata[343:336];
	assign hdr_in.dst_mark        = s_tdata[351:344];
	assign hdr_in.header_checksum = s_tdata[367:352];

	// stage 2 loads whenever the result register is empty or being drained;
	// stage 1 loads whenever it is empty or moving on into stage 2
	assign load_s2  = !valid_s2 || m_tready;
	assign load_s1  = !valid_s1 || load_s2;
	assign s_tready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (load_s1 && s_tvalid) begin
			hdr_s1 <= hdr_in;
		end
		if (load_s2 && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	// header check, prefix match, byte insertion and checksum update in one pass
	bghr_rewrite u_rewrite (
		.hdr (hdr_s1),
		.cfg (cfg),
		.res (res_next)
	);

	// pack the result item
	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.new_checksum, res_s2.new_dst_mark, res_s2.new_src_mark,
		res_s2.new_src_ext_low, res_s2.new_src_ext_high, res_s2.new_dst_address,
		res_s2.new_src_address};
	assign m_tuser  = {res_s2.mark_overrun, res_s2.drop};

`include "border_gateway_header_rewrite_unit_macros.svh"

	// a dropped header never reports a skipped rewrite
	`BGHR_ASSERT_NOW(a_drop_no_overrun, m_tvalid && m_tuser[0], !m_tuser[1], "drop with overrun")
	// a stalled stage 1 item stays put
	`BGHR_ASSERT_NEXT(a_s1_hold, valid_s1 && !load_s2, valid_s1, "stage 1 item lost")
	// no input is taken while both stages are full and stalled
	`BGHR_ASSERT_NOW(a_full_stall, valid_s1 && valid_s2 && !m_tready, !s_tready, "accept while full")
	// an empty input stage always takes an item
	`BGHR_ASSERT_NOW(a_empty_ready, !valid_s1, s_tready, "empty stage not ready")

endmodule

@@ bench/border_gateway_header_rewrite_unit_test.sv @@
module border_gateway_header_rewrite_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	// receiver stall patterns, switched at random
	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_PERIODIC
	} ready_mode_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// header input side
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// from bit 0: major_version minor_version proto src_address dst_address src_ext_high
	// src_ext_low dst_ext_high dst_ext_low src_mark dst_mark header_checksum
	logic [367:0] s_tdata = '0;

	// rewritten header side
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// from bit 0: new_src_address new_dst_address new_src_ext_high new_src_ext_low
	// new_src_mark new_dst_mark new_checksum
	logic [223:0] m_tdata;
	// from bit 0: drop mark_overrun
	logic [1:0]   m_tuser;

	// register port
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	// our copy of the gateway registers, starting from the reset values
	bghr_pkg::cfg_t gateway_cfg = '{downstream_prefix: 32'h0,
		prefix_length: bghr_pkg::PREFIX_LENGTH_RESET,
		upstream_address: 32'h0, protocol_number: bghr_pkg::PROTOCOL_NUMBER_RESET};

	// rewritten headers still owed by the block, oldest first
	bghr_pkg::res_t pending_rewrites[$];

	int unsigned mismatches = 0;
	int unsigned headers_sent = 0;
	int unsigned results_checked = 0;
	int unsigned drops_seen = 0;
	int unsigned overruns_seen = 0;
	int unsigned settings_used = 0;
	int unsigned burst_left = 0;
	int unsigned ready_left = 0;
	int unsigned ready_phase = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	bghr_pkg::res_t got_rewrite;
	bghr_pkg::res_t want_rewrite;

	border_gateway_header_rewrite_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 20 ns clock
	initial begin
		forever #10 clk = ~clk;
	end

	// hard stop for a hung block
	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// one line per mismatch, quiet after the first few dozen
	task automatic report_mismatch(input string msg);
		if (mismatches < 40)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h want %h",
				results_checked, name, got, want));
	endtask

	// mask for the top len bits, len already clamped to 32
	function automatic logic [31:0] prefix_mask(input int len);
		if (len == 0)
			return 32'h0;
		return 32'hFFFF_FFFF << (32 - len);
	endfunction

	// one's-complement checksum adjust for a 32-bit word that changed
	function automatic logic [15:0] refold_checksum(input logic [15:0] hc,
			input logic [31:0] oldw, input logic [31:0] neww);
		logic [15:0] nhc;
		logic [15:0] nhi;
		logic [15:0] nlo;
		logic [31:0] s;
		nhc = ~hc;
		nhi = ~oldw[31:16];
		nlo = ~oldw[15:0];
		s = nhc + nhi + nlo + neww[31:16] + neww[15:0];
		s = s[15:0] + s[31:16];
		s = s[15:0] + s[31:16];
		return ~s[15:0];
	endfunction

	// expected rewrite of one header under the current registers
	function automatic bghr_pkg::res_t predict_rewrite(input bghr_pkg::hdr_t h);
		bghr_pkg::res_t r;
		logic [7:0] sb[16];
		logic [7:0] db[16];
		logic [31:0] nd;
		logic [31:0] up;
		logic [31:0] pfx;
		int len;
		int shlen;
		int nm;
		int start;
		r.drop = 1'b0;
		r.mark_overrun = 1'b0;
		r.new_src_address = h.src_address;
		r.new_dst_address = h.dst_address;
		r.new_src_ext_high = h.src_ext_high;
		r.new_src_ext_low = h.src_ext_low;
		r.new_src_mark = h.src_mark;
		r.new_dst_mark = h.dst_mark;
		r.new_checksum = h.header_checksum;
		// failed header check: everything passes through untouched
		if (h.major_version != bghr_pkg::VERSION_MAJOR
				|| h.minor_version != bghr_pkg::VERSION_MINOR
				|| h.proto != gateway_cfg.protocol_number) begin
			r.drop = 1'b1;
			return r;
		end
		up = gateway_cfg.upstream_address;
		pfx = gateway_cfg.downstream_prefix;
		// lengths past 32 behave as 32
		len = gateway_cfg.prefix_length > 32 ? 32 : gateway_cfg.prefix_length;
		shlen = (32 - len) / 8;
		for (int i = 0; i < 8; i++) begin
			sb[i] = h.src_ext_high[63 - 8 * i -: 8];
			sb[i + 8] = h.src_ext_low[63 - 8 * i -: 8];
			db[i] = h.dst_ext_high[63 - 8 * i -: 8];
			db[i + 8] = h.dst_ext_low[63 - 8 * i -: 8];
		end
		// return path: stash upstream address into the source extended bytes
		if ((h.src_address & prefix_mask(len)) == (pfx & prefix_mask(len))) begin
			nm = h.src_mark + shlen;
			if (nm > 12) begin
				r.mark_overrun = 1'b1;
			end else begin
				for (int i = 0; i < 4; i++)
					sb[12 - nm + i] = up[31 - 8 * i -: 8];
				for (int i = 0; i < 8; i++) begin
					r.new_src_ext_high[63 - 8 * i -: 8] = sb[i];
					r.new_src_ext_low[63 - 8 * i -: 8] = sb[i + 8];
				end
				r.new_src_mark = nm[7:0];
				r.new_checksum = refold_checksum(r.new_checksum, h.src_address, up);
				r.new_src_address = up;
			end
		end
		// forward path: rebuild destination from prefix plus unconsumed bytes
		if (h.dst_address == up && h.dst_mark != 8'd0) begin
			if (h.dst_mark > 16 || h.dst_mark < shlen) begin
				r.mark_overrun = 1'b1;
			end else begin
				nd = 32'h0;
				start = 16 - h.dst_mark;
				for (int k = 0; k < 4; k++) begin
					if (k < 4 - shlen)
						nd = {nd[23:0], pfx[31 - 8 * k -: 8]};
					else
						nd = {nd[23:0], db[(start + k - (4 - shlen)) & 15]};
				end
				r.new_dst_mark = h.dst_mark - shlen[7:0];
				r.new_checksum = refold_checksum(r.new_checksum, h.dst_address, nd);
				r.new_dst_address = nd;
			end
		end
		return r;
	endfunction

	function automatic logic [367:0] pack_header(input bghr_pkg::hdr_t h);
		return {h.header_checksum, h.dst_mark, h.src_mark, h.dst_ext_low, h.dst_ext_high,
			h.src_ext_low, h.src_ext_high, h.dst_address, h.src_address, h.proto,
			h.minor_version, h.major_version};
	endfunction

	// valid header with random extended bytes and checksum
	function automatic bghr_pkg::hdr_t good_header(input logic [31:0] src,
			input logic [31:0] dst, input logic [7:0] smark, input logic [7:0] dmark);
		bghr_pkg::hdr_t h;
		h.major_version = bghr_pkg::VERSION_MAJOR;
		h.minor_version = bghr_pkg::VERSION_MINOR;
		h.proto = gateway_cfg.protocol_number;
		h.src_address = src;
		h.dst_address = dst;
		h.src_ext_high = {$urandom, $urandom};
		h.src_ext_low = {$urandom, $urandom};
		h.dst_ext_high = {$urandom, $urandom};
		h.dst_ext_low = {$urandom, $urandom};
		h.src_mark = smark;
		h.dst_mark = dmark;
		h.header_checksum = 16'($urandom);
		return h;
	endfunction

	// mostly well-formed headers aimed at the prefix and the upstream address
	function automatic bghr_pkg::hdr_t random_header();
		bghr_pkg::hdr_t h;
		int unsigned sel;
		int len;
		logic [31:0] msk;
		h = good_header($urandom, $urandom, 8'($urandom), 8'($urandom));
		sel = $urandom_range(0, 99);
		if (sel >= 92) begin
			// pure noise in the header check fields
			h.major_version = 4'($urandom);
			h.minor_version = 4'($urandom);
			h.proto = 8'($urandom);
		end else if (sel >= 86) begin
			h.minor_version = 4'($urandom);
		end else if (sel >= 80) begin
			// protocol off by one bit
			h.proto = gateway_cfg.protocol_number ^ (8'h1 << $urandom_range(0, 7));
		end
		len = gateway_cfg.prefix_length > 32 ? 32 : gateway_cfg.prefix_length;
		msk = prefix_mask(len);
		if ($urandom_range(0, 99) < 55)
			h.src_address = (gateway_cfg.downstream_prefix & msk) | (h.src_address & ~msk);
		if ($urandom_range(0, 99) < 45)
			h.dst_address = gateway_cfg.upstream_address;
		if ($urandom_range(0, 99) < 75)
			h.src_mark = 8'($urandom_range(0, 13));
		if ($urandom_range(0, 99) < 75)
			h.dst_mark = 8'($urandom_range(0, 17));
		return h;
	endfunction

	function automatic bghr_pkg::cfg_t make_cfg(input logic [31:0] pfx, input logic [5:0] len,
			input logic [31:0] up, input logic [7:0] proto);
		bghr_pkg::cfg_t c;
		c.downstream_prefix = pfx;
		c.prefix_length = len;
		c.upstream_address = up;
		c.protocol_number = proto;
		return c;
	endfunction

	function automatic bghr_pkg::cfg_t random_cfg();
		logic [5:0] len;
		case ($urandom_range(0, 9))
			0: len = 6'd0;
			1: len = 6'd8;
			2: len = 6'd16;
			3: len = 6'd24;
			4: len = 6'd32;
			default: len = 6'($urandom_range(0, 63));
		endcase
		return make_cfg($urandom, len, $urandom, 8'($urandom));
	endfunction

	// receiver stall pattern: modes of random length, always-ready among them
	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode = ready_mode_t'($urandom_range(0, 3));
			ready_left = $urandom_range(10, 80);
		end
		ready_left--;
		ready_phase++;
		case (ready_mode)
			READY_ALWAYS:   m_tready <= 1'b1;
			READY_COIN:     m_tready <= 1'($urandom_range(0, 1));
			READY_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
			READY_PERIODIC: m_tready <= (ready_phase % 5 < 2);
		endcase
	end

	// result checker: each accepted item against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rewrites.size() == 0) begin
				report_mismatch("result with no header waiting");
			end else begin
				want_rewrite = pending_rewrites.pop_front();
				got_rewrite.drop = m_tuser[0];
				got_rewrite.mark_overrun = m_tuser[1];
				got_rewrite.new_src_address = m_tdata[31:0];
				got_rewrite.new_dst_address = m_tdata[63:32];
				got_rewrite.new_src_ext_high = m_tdata[127:64];
				got_rewrite.new_src_ext_low = m_tdata[191:128];
				got_rewrite.new_src_mark = m_tdata[199:192];
				got_rewrite.new_dst_mark = m_tdata[207:200];
				got_rewrite.new_checksum = m_tdata[223:208];
				check_field("drop", got_rewrite.drop, want_rewrite.drop);
				check_field("mark_overrun", got_rewrite.mark_overrun,
					want_rewrite.mark_overrun);
				check_field("new_src_address", got_rewrite.new_src_address,
					want_rewrite.new_src_address);
				check_field("new_dst_address", got_rewrite.new_dst_address,
					want_rewrite.new_dst_address);
				check_field("new_src_ext_high", got_rewrite.new_src_ext_high,
					want_rewrite.new_src_ext_high);
				check_field("new_src_ext_low", got_rewrite.new_src_ext_low,
					want_rewrite.new_src_ext_low);
				check_field("new_src_mark", got_rewrite.new_src_mark,
					want_rewrite.new_src_mark);
				check_field("new_dst_mark", got_rewrite.new_dst_mark,
					want_rewrite.new_dst_mark);
				check_field("new_checksum", got_rewrite.new_checksum,
					want_rewrite.new_checksum);
				results_checked++;
			end
		end
	end

	// send one header item; bursts of random length with random gaps between
	task automatic send_header(input bghr_pkg::hdr_t h);
		int unsigned gap;
		bghr_pkg::res_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			// zero gap often, so bursts run back to back
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= pack_header(h);
		// item taken at the edge where tready is seen high
		do @(posedge clk); while (!s_tready);
		r = predict_rewrite(h);
		pending_rewrites.push_back(r);
		headers_sent++;
		if (r.drop)
			drops_seen++;
		if (r.mark_overrun)
			overruns_seen++;
	endtask

	// stop sending and wait for every owed result, then let the pipe settle
	task automatic drain_results();
		int unsigned waited;
		waited = 0;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_rewrites.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_rewrites.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_rewrites.size()));
			pending_rewrites.delete();
		end
		// two-stage pipe, then a spare wait so it can settle
		repeat (4) @(posedge clk);
	endtask

	// register write: setup phase, access phase, then an idle phase
	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (index)
			bghr_pkg::REG_DOWNSTREAM_PREFIX: gateway_cfg.downstream_prefix = value;
			bghr_pkg::REG_PREFIX_LENGTH:     gateway_cfg.prefix_length = value[5:0];
			bghr_pkg::REG_UPSTREAM_ADDRESS:  gateway_cfg.upstream_address = value;
			bghr_pkg::REG_PROTOCOL_NUMBER:   gateway_cfg.protocol_number = value[7:0];
		endcase
	endtask

	// new register setting, only once the block is idle
	task automatic apply_config(input bghr_pkg::cfg_t c);
		drain_results();
		write_register(bghr_pkg::REG_DOWNSTREAM_PREFIX, c.downstream_prefix);
		// junk in the unused upper bits must be ignored
		write_register(bghr_pkg::REG_PREFIX_LENGTH, {26'($urandom), c.prefix_length});
		write_register(bghr_pkg::REG_UPSTREAM_ADDRESS, c.upstream_address);
		write_register(bghr_pkg::REG_PROTOCOL_NUMBER, {24'($urandom), c.protocol_number});
		settings_used++;
	endtask

	// registers at reset: prefix 0/24, upstream 0, protocol 155
	task automatic test_reset_defaults();
		send_header(good_header(32'h0000_0012, 32'h0, 8'd0, 8'd1));
		send_header('0);
	endtask

	// version and protocol checks, field extremes
	task automatic test_header_check();
		bghr_pkg::hdr_t h;
		apply_config(make_cfg(32'h0A00_0000, 6'd24, 32'hC633_6401,
			bghr_pkg::PROTOCOL_NUMBER_RESET));
		h = good_header(32'h0A00_0001, 32'hC633_6401, 8'd0, 8'd1);
		h.proto = bghr_pkg::PROTOCOL_NUMBER_RESET - 8'd1;
		send_header(h);
		h = good_header(32'h0A00_0001, 32'hC633_6401, 8'd0, 8'd1);
		h.major_version = bghr_pkg::VERSION_MINOR;
		send_header(h);
		h = good_header(32'h0A00_0001, 32'hC633_6401, 8'd0, 8'd1);
		h.minor_version = bghr_pkg::VERSION_MAJOR;
		send_header(h);
		h = '1;
		send_header(h);
		// all ones but a passing header check: no match, nothing rewritten
		h.major_version = bghr_pkg::VERSION_MAJOR;
		h.minor_version = bghr_pkg::VERSION_MINOR;
		h.proto = gateway_cfg.protocol_number;
		send_header(h);
	endtask

	// source rewrite up to the last byte slot and past it
	task automatic test_source_rewrite();
		send_header(good_header(32'h0A00_00FE, 32'h0808_0808, 8'd0, 8'd0));
		send_header(good_header(32'h0A00_00FE, 32'h0808_0808, 8'd11, 8'd0));
		send_header(good_header(32'h0A00_00FE, 32'h0808_0808, 8'd12, 8'd0));
		send_header(good_header(32'h0A00_00FE, 32'h0808_0808, 8'd255, 8'd0));
	endtask

	// destination mark zero, in range, and past sixteen
	task automatic test_destination_rewrite();
		send_header(good_header(32'h0808_0808, gateway_cfg.upstream_address, 8'd0, 8'd0));
		send_header(good_header(32'h0808_0808, gateway_cfg.upstream_address, 8'd0, 8'd1));
		send_header(good_header(32'h0808_0808, gateway_cfg.upstream_address, 8'd0, 8'd16));
		send_header(good_header(32'h0808_0808, gateway_cfg.upstream_address, 8'd0, 8'd17));
		send_header(good_header(32'h0808_0808, gateway_cfg.upstream_address, 8'd0, 8'd255));
	endtask

	// both paths on one header, checksum adjusted twice
	task automatic test_both_rewrites();
		send_header(good_header(32'h0A00_0033, gateway_cfg.upstream_address, 8'd3, 8'd5));
	endtask

	// short, zero, full, oversize and odd prefix lengths
	task automatic test_prefix_lengths();
		apply_config(make_cfg(32'hC0A8_0000, 6'd8, 32'h6440_0001, 8'hFF));
		// destination mark below the shift length
		send_header(good_header(32'h0102_0304, gateway_cfg.upstream_address, 8'd0, 8'd2));
		send_header(good_header(32'hC012_3456, gateway_cfg.upstream_address, 8'd9, 8'd3));
		// zero length matches any source
		apply_config(make_cfg(32'hFFFF_FFFF, 6'd0, 32'h0, 8'h00));
		send_header(good_header(32'h1234_5678, 32'h0, 8'd8, 8'd4));
		apply_config(make_cfg(32'h0A0B_0C0D, 6'd32, 32'hFFFF_FFFF, 8'd17));
		send_header(good_header(32'h0A0B_0C0D, 32'hFFFF_FFFF, 8'd12, 8'd1));
		send_header(good_header(32'h0A0B_0C0C, 32'hFFFF_FFFF, 8'd0, 8'd0));
		// above 32 acts as a full-length prefix
		apply_config(make_cfg(32'h0A0B_0C0D, 6'd40, 32'hFFFF_FFFF, 8'd17));
		send_header(good_header(32'h0A0B_0C0D, 32'hFFFF_FFFF, 8'd5, 8'd16));
		apply_config(make_cfg(32'h0A00_0000, 6'd12, 32'h5A5A_A5A5, 8'd155));
		send_header(good_header(32'h0A0F_FFFF, 32'h5A5A_A5A5, 8'd2, 8'd2));
	endtask

	// random headers over several settings, extremes first
	task automatic test_random_traffic();
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0)
				apply_config(make_cfg(32'h0, 6'd0, 32'h0, 8'h00));
			else if (phase == 1)
				apply_config(make_cfg(32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF));
			else
				apply_config(random_cfg());
			repeat (170) send_header(random_header());
		end
	endtask

	initial begin
		// reset held at start-up, then released once
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_header_check();
		test_source_rewrite();
		test_destination_rewrite();
		test_both_rewrites();
		test_prefix_lengths();
		test_random_traffic();

		drain_results();
		$display("sent %0d headers under %0d register settings, %0d results checked",
			headers_sent, settings_used, results_checked);
		$display("of those %0d dropped by the header check, %0d with a skipped rewrite",
			drops_seen, overruns_seen);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
